// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
// ASSERT_CLK expects signals named clk and rst_n in the scope of use; ASSERT_ALWAYS needs only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ccnr_pkg.sv
package ccnr_pkg;

  // Default grid size
  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  localparam int COLOUR_W = 24;
  localparam int MASK_W   = 9;
  localparam int TALLY_W  = 4;
  localparam int CODE_W   = 2;
  localparam int STEP_W   = 4;
  localparam int REG_W    = 3;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result codes
  localparam logic [CODE_W-1:0] CODE_NO_MATCH = 2'd0;
  localparam logic [CODE_W-1:0] CODE_MATCH    = 2'd1;
  localparam logic [CODE_W-1:0] CODE_MISS     = 2'd2;

  // Register indexes
  localparam logic [REG_W-1:0] REG_CENTRE_A = 3'd0;
  localparam logic [REG_W-1:0] REG_CENTRE_B = 3'd1;
  localparam logic [REG_W-1:0] REG_CENTRE_C = 3'd2;
  localparam logic [REG_W-1:0] REG_NB_A     = 3'd3;
  localparam logic [REG_W-1:0] REG_NB_B     = 3'd4;
  localparam logic [REG_W-1:0] REG_NB_C     = 3'd5;
  localparam logic [REG_W-1:0] REG_MASK     = 3'd6;

  // Register reset values
  localparam logic [COLOUR_W-1:0] RST_CENTRE = 24'd0;
  localparam logic [COLOUR_W-1:0] RST_NB_A   = 24'd255;
  localparam logic [COLOUR_W-1:0] RST_NB_B   = 24'd16711680;
  localparam logic [COLOUR_W-1:0] RST_NB_C   = 24'd16777215;
  localparam logic [MASK_W-1:0]   RST_MASK   = 9'd8;

  // Program steps that are jump targets
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd11;

  // Grid address to drive on a step
  typedef enum logic [3:0] {
    ADDR_CENTRE,
    ADDR_UL,
    ADDR_U,
    ADDR_UR,
    ADDR_R,
    ADDR_DR,
    ADDR_D,
    ADDR_DL,
    ADDR_L
  } addr_sel_t;

  // Branch conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IS_WRITE,
    COND_CENTRE_MISS,
    COND_OUT_BUSY
  } cond_t;

  // One control word of the program
  typedef struct packed {
    logic              accept;
    logic              wr_en;
    logic              chk_centre;
    logic              acc;
    logic              emit;
    addr_sel_t         addr_sel;
    cond_t             hold;
    cond_t             jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Flags the sequencer branches on
  typedef struct packed {
    logic in_valid;
    logic is_write;
    logic centre_miss;
    logic out_busy;
  } status_t;

  // Configuration register file
  typedef struct packed {
    logic [COLOUR_W-1:0] centre_a;
    logic [COLOUR_W-1:0] centre_b;
    logic [COLOUR_W-1:0] centre_c;
    logic [COLOUR_W-1:0] nb_a;
    logic [COLOUR_W-1:0] nb_b;
    logic [COLOUR_W-1:0] nb_c;
    logic [MASK_W-1:0]   mask;
  } cfg_t;

endpackage

// File: sv/colour_cell_neighbour_rule_match.sv
// Channel | Ports                                       | Direction | Moves on
// in      | in_valid in_stall in_command in_row ...     | input     | valid && !stall
// out     | out_valid out_stall out_match_code          | output    | valid && !stall
// cfg     | cfg_valid cfg_ready cfg_index cfg_data      | input     | valid && ready
// A query runs one accept step, one centre read, eight neighbour
// reads and a tally step through the single grid memory port, then the emit
// step, which loads the output register. A centre miss jumps straight to
// the emit step. A write ends after the accept step and the write step.
// Reset clears the step counter and the output valid; the grid is not cleared.
// A stalled result holds the sequencer at the emit step, which stalls the input.
module colour_cell_neighbour_rule_match #(
  parameter int GRID_ROWS = ccnr_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = ccnr_pkg::GRID_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [5:0]                    in_row,
  input  logic [5:0]                    in_column,
  input  logic [ccnr_pkg::COLOUR_W-1:0] in_cell_colour,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ccnr_pkg::CODE_W-1:0]   out_match_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccnr_pkg::REG_W-1:0]    cfg_index,
  input  logic [ccnr_pkg::COLOUR_W-1:0] cfg_data
);

  ccnr_pkg::ctrl_t   ctrl;
  ccnr_pkg::status_t status;
  ccnr_pkg::cfg_t    cfg_r;

  logic                        take;
  logic                        is_write;
  logic                        centre_miss;
  logic [ccnr_pkg::CODE_W-1:0] code;
  logic                        out_valid_r;
  logic [ccnr_pkg::CODE_W-1:0] out_code_r;
  logic                        out_busy;

  assign in_stall  = !ctrl.accept;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid_r && out_stall;

  assign status.in_valid    = in_valid;
  assign status.is_write    = is_write;
  assign status.centre_miss = centre_miss;
  assign status.out_busy    = out_busy;

  ccnr_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  ccnr_datapath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_datapath (
    .clk            (clk),
    .ctrl           (ctrl),
    .cfg            (cfg_r),
    .take           (take),
    .in_command     (in_command),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_cell_colour (in_cell_colour),
    .is_write       (is_write),
    .centre_miss    (centre_miss),
    .code           (code)
  );

  // Configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.centre_a <= ccnr_pkg::RST_CENTRE;
      cfg_r.centre_b <= ccnr_pkg::RST_CENTRE;
      cfg_r.centre_c <= ccnr_pkg::RST_CENTRE;
      cfg_r.nb_a     <= ccnr_pkg::RST_NB_A;
      cfg_r.nb_b     <= ccnr_pkg::RST_NB_B;
      cfg_r.nb_c     <= ccnr_pkg::RST_NB_C;
      cfg_r.mask     <= ccnr_pkg::RST_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccnr_pkg::REG_CENTRE_A: cfg_r.centre_a <= cfg_data;
        ccnr_pkg::REG_CENTRE_B: cfg_r.centre_b <= cfg_data;
        ccnr_pkg::REG_CENTRE_C: cfg_r.centre_c <= cfg_data;
        ccnr_pkg::REG_NB_A:     cfg_r.nb_a     <= cfg_data;
        ccnr_pkg::REG_NB_B:     cfg_r.nb_b     <= cfg_data;
        ccnr_pkg::REG_NB_C:     cfg_r.nb_c     <= cfg_data;
        ccnr_pkg::REG_MASK:     cfg_r.mask     <= cfg_data[ccnr_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: drain on take, load on the emit step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && !out_busy) begin
      out_code_r <= code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_match_code = out_code_r;

endmodule

// File: sv/ccnr_seq.sv
module ccnr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  ccnr_pkg::status_t status,
  output ccnr_pkg::ctrl_t   ctrl
);

  logic [ccnr_pkg::STEP_W-1:0] step_r;
  logic [ccnr_pkg::STEP_W-1:0] step_nxt;

  // Build one control word
  function automatic ccnr_pkg::ctrl_t cw(
    input logic                        accept,
    input logic                        wr_en,
    input logic                        chk_centre,
    input logic                        acc,
    input logic                        emit,
    input ccnr_pkg::addr_sel_t         addr_sel,
    input ccnr_pkg::cond_t             hold,
    input ccnr_pkg::cond_t             jmp,
    input logic [ccnr_pkg::STEP_W-1:0] target
  );
    ccnr_pkg::ctrl_t w;
    w.accept     = accept;
    w.wr_en      = wr_en;
    w.chk_centre = chk_centre;
    w.acc        = acc;
    w.emit       = emit;
    w.addr_sel   = addr_sel;
    w.hold       = hold;
    w.jmp        = jmp;
    w.target     = target;
    return w;
  endfunction

  // Program: accept, write or read centre, read eight neighbours, tally, emit
  function automatic ccnr_pkg::ctrl_t ucode(input logic [ccnr_pkg::STEP_W-1:0] s);
    ccnr_pkg::ctrl_t w;
    case (s)
      4'd0:  w = cw(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ccnr_pkg::ADDR_CENTRE,
                    ccnr_pkg::COND_NO_INPUT, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd1:  w = cw(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ccnr_pkg::ADDR_CENTRE,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_IS_WRITE, ccnr_pkg::STEP_IDLE);
      4'd2:  w = cw(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ccnr_pkg::ADDR_UL,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_CENTRE_MISS, ccnr_pkg::STEP_EMIT);
      4'd3:  w = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ccnr_pkg::ADDR_U,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd4:  w = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ccnr_pkg::ADDR_UR,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd5:  w = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ccnr_pkg::ADDR_R,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd6:  w = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ccnr_pkg::ADDR_DR,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd7:  w = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ccnr_pkg::ADDR_D,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd8:  w = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ccnr_pkg::ADDR_DL,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd9:  w = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ccnr_pkg::ADDR_L,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd10: w = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ccnr_pkg::ADDR_CENTRE,
                    ccnr_pkg::COND_NEVER, ccnr_pkg::COND_NEVER, ccnr_pkg::STEP_IDLE);
      4'd11: w = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ccnr_pkg::ADDR_CENTRE,
                    ccnr_pkg::COND_OUT_BUSY, ccnr_pkg::COND_ALWAYS, ccnr_pkg::STEP_IDLE);
      default: w = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ccnr_pkg::ADDR_CENTRE,
                      ccnr_pkg::COND_NEVER, ccnr_pkg::COND_ALWAYS, ccnr_pkg::STEP_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic cond_true(input ccnr_pkg::cond_t c, input ccnr_pkg::status_t st);
    logic t;
    case (c)
      ccnr_pkg::COND_NEVER:       t = 1'b0;
      ccnr_pkg::COND_ALWAYS:      t = 1'b1;
      ccnr_pkg::COND_NO_INPUT:    t = !st.in_valid;
      ccnr_pkg::COND_IS_WRITE:    t = st.is_write;
      ccnr_pkg::COND_CENTRE_MISS: t = st.centre_miss;
      ccnr_pkg::COND_OUT_BUSY:    t = st.out_busy;
      default:                    t = 1'b0;
    endcase
    return t;
  endfunction

  assign ctrl = ucode(step_r);

  // Hold, jump or advance the step counter
  always_comb begin
    if (cond_true(ctrl.hold, status)) begin
      step_nxt = step_r;
    end else if (cond_true(ctrl.jmp, status)) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ccnr_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: sv/ccnr_datapath.sv
module ccnr_datapath #(
  parameter int GRID_ROWS = ccnr_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = ccnr_pkg::GRID_COLS_DEF
) (
  input  logic                          clk,
  input  ccnr_pkg::ctrl_t               ctrl,
  input  ccnr_pkg::cfg_t                cfg,
  input  logic                          take,
  input  logic                          in_command,
  input  logic [5:0]                    in_row,
  input  logic [5:0]                    in_column,
  input  logic [ccnr_pkg::COLOUR_W-1:0] in_cell_colour,
  output logic                          is_write,
  output logic                          centre_miss,
  output logic [ccnr_pkg::CODE_W-1:0]   code
);

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int DEPTH  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [ROW_W-1:0] row_mod_tbl [64];
  logic [COL_W-1:0] col_mod_tbl [64];

  logic                          cmd_r;
  logic [ROW_W-1:0]              row_r;
  logic [COL_W-1:0]              col_r;
  logic [ccnr_pkg::COLOUR_W-1:0] colour_r;
  logic [ccnr_pkg::TALLY_W-1:0]  tally_r;
  logic                          miss_r;

  logic [ROW_W-1:0]  row_up, row_dn, row_sel;
  logic [COL_W-1:0]  col_lf, col_rt, col_sel;
  logic [ADDR_W-1:0] addr;
  logic              nb_hit;

  logic [ccnr_pkg::COLOUR_W-1:0] grid_mem [DEPTH];
  logic [ccnr_pkg::COLOUR_W-1:0] rd_data_r;

  // Fold the six-bit address fields into the grid
  for (genvar i = 0; i < 64; i++) begin : g_mod
    assign row_mod_tbl[i] = ROW_W'(i % GRID_ROWS);
    assign col_mod_tbl[i] = COL_W'(i % GRID_COLS);
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r    <= in_command;
      row_r    <= row_mod_tbl[in_row];
      col_r    <= col_mod_tbl[in_column];
      colour_r <= in_cell_colour;
    end
  end

  // Wrapped neighbour coordinates
  assign row_up = (row_r == '0) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(row_r - 1'b1);
  assign row_dn = (row_r == ROW_W'(GRID_ROWS - 1)) ? '0 : ROW_W'(row_r + 1'b1);
  assign col_lf = (col_r == '0) ? COL_W'(GRID_COLS - 1) : COL_W'(col_r - 1'b1);
  assign col_rt = (col_r == COL_W'(GRID_COLS - 1)) ? '0 : COL_W'(col_r + 1'b1);

  always_comb begin
    case (ctrl.addr_sel)
      ccnr_pkg::ADDR_CENTRE: begin row_sel = row_r;  col_sel = col_r;  end
      ccnr_pkg::ADDR_UL:     begin row_sel = row_up; col_sel = col_lf; end
      ccnr_pkg::ADDR_U:      begin row_sel = row_up; col_sel = col_r;  end
      ccnr_pkg::ADDR_UR:     begin row_sel = row_up; col_sel = col_rt; end
      ccnr_pkg::ADDR_R:      begin row_sel = row_r;  col_sel = col_rt; end
      ccnr_pkg::ADDR_DR:     begin row_sel = row_dn; col_sel = col_rt; end
      ccnr_pkg::ADDR_D:      begin row_sel = row_dn; col_sel = col_r;  end
      ccnr_pkg::ADDR_DL:     begin row_sel = row_dn; col_sel = col_lf; end
      ccnr_pkg::ADDR_L:      begin row_sel = row_r;  col_sel = col_lf; end
      default:               begin row_sel = row_r;  col_sel = col_r;  end
    endcase
  end

  assign addr = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(GRID_COLS) + ADDR_W'(col_sel));

  // Grid memory, one port, registered read
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && is_write) begin
      grid_mem[addr] <= colour_r;
    end
    rd_data_r <= grid_mem[addr];
  end

  assign is_write    = (cmd_r == ccnr_pkg::CMD_WRITE);
  assign centre_miss = (rd_data_r != cfg.centre_a) && (rd_data_r != cfg.centre_b) &&
                       (rd_data_r != cfg.centre_c);
  assign nb_hit      = (rd_data_r == cfg.nb_a) || (rd_data_r == cfg.nb_b) ||
                       (rd_data_r == cfg.nb_c);

  // Tally matching neighbours and note a centre miss
  always_ff @(posedge clk) begin
    if (take) begin
      tally_r <= '0;
      miss_r  <= 1'b0;
    end else begin
      if (ctrl.chk_centre) begin
        miss_r <= centre_miss;
      end
      if (ctrl.acc) begin
        tally_r <= tally_r + ccnr_pkg::TALLY_W'(nb_hit);
      end
    end
  end

  assign code = miss_r ? ccnr_pkg::CODE_MISS :
                (cfg.mask[tally_r] ? ccnr_pkg::CODE_MATCH : ccnr_pkg::CODE_NO_MATCH);

endmodule

// File: sv/ccnr_checker.sv
`include "assert_macros.svh"

module ccnr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ccnr_pkg::CODE_W-1:0]   out_match_code
);

  // A stalled result stays put
  `ASSERT_CLK(a_out_hold,
              out_valid && out_stall |=> out_valid && $stable(out_match_code),
              "result changed while stalled")

  // Only the three defined codes leave the block
  `ASSERT_CLK(a_code_range, out_valid |-> out_match_code <= ccnr_pkg::CODE_MISS,
              "undefined result code")

  // An accepted transaction is followed by a stall of the input
  `ASSERT_CLK(a_no_back_to_back, in_valid && !in_stall |=> in_stall,
              "two transactions in a row")

  // A result never appears right after an acceptance
  `ASSERT_CLK(a_result_latency, $rose(out_valid) |-> !$past(in_valid && !in_stall),
              "result too early")

  // Reset empties the output register
  `ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind colour_cell_neighbour_rule_match ccnr_checker u_ccnr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_match_code (out_match_code)
);
